// ===== design/baro_comp_pkg.sv =====
// ============================================================================
// Barometer compensation package
// Shared types, register indexes and oversampling scale tables.
// ============================================================================
`default_nettype none

package baro_comp_pkg;

    localparam int RAW_W       = 24;
    localparam int RAW_BITS_DEF = 24;
    localparam int TOUT_W      = 24;
    localparam int POUT_W      = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 56;
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_TEMP_SCALE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PRESS_SCALE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_C0_C1 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_C00_C10 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_C01_C11 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_C20_C21_C30 = 3'd5;

    typedef struct packed {
        logic signed [RAW_W-1:0] praw;
        logic signed [RAW_W-1:0] traw;
    } raw_item_t;

    typedef struct packed {
        logic      vld;
        raw_item_t item;
    } item_msg_t;

    typedef struct packed {
        logic [2:0]         t_idx;
        logic [2:0]         p_idx;
        logic signed [11:0] c0;
        logic signed [11:0] c1;
        logic signed [19:0] c00;
        logic signed [19:0] c10;
        logic signed [15:0] c01;
        logic signed [15:0] c11;
        logic signed [15:0] c20;
        logic signed [15:0] c21;
        logic signed [15:0] c30;
    } coef_t;

    // Every scale factor is (2^m - 1) * 2^s with s either 19 or 13.
    // Half of the scale factor, added before the divide for rounding.
    function automatic logic [21:0] scale_half(input logic [2:0] idx);
        logic [21:0] h;
        case (idx)
            3'd0:    h = 22'd262144;
            3'd1:    h = 22'd786432;
            3'd2:    h = 22'd1835008;
            3'd3:    h = 22'd1966080 + 22'd1966080;
            3'd4:    h = 22'd126976;
            3'd5:    h = 22'd258048;
            3'd6:    h = 22'd520192;
            default: h = 22'd1044480;
        endcase
        return h;
    endfunction

    // True when the power-of-two part of the factor is 2^19.
    function automatic logic scale_wide(input logic [2:0] idx);
        return !idx[2];
    endfunction

    function automatic logic [7:0] scale_div(input logic [2:0] idx);
        logic [7:0] d;
        case (idx)
            3'd0:    d = 8'd1;
            3'd1:    d = 8'd3;
            3'd2:    d = 8'd7;
            3'd3:    d = 8'd15;
            3'd4:    d = 8'd31;
            3'd5:    d = 8'd63;
            3'd6:    d = 8'd127;
            default: d = 8'd255;
        endcase
        return d;
    endfunction

    // floor((2^32 - 1) / d) for the odd divisor above.
    function automatic logic [31:0] scale_recip(input logic [2:0] idx);
        logic [31:0] m;
        case (idx)
            3'd0:    m = 32'd4294967295;
            3'd1:    m = 32'd1431655765;
            3'd2:    m = 32'd613566756;
            3'd3:    m = 32'd286331153;
            3'd4:    m = 32'd138547332;
            3'd5:    m = 32'd68174084;
            3'd6:    m = 32'd33818640;
            default: m = 32'd16843009;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== design/barometer_compensation_unit.sv =====
// Path from an input transfer to its result: front register, queue, nine datapath stages
// and the output register.
// Throughput: one item per clock cycle while the output is not stalled; every stage, including the
// reciprocal-multiply scaling divide and the split wide products, is pipelined.
// Reset (aresetn, synchronous, active low) empties the front register, queue and
// pipeline and clears every configuration register to zero; no clearing pass is needed.
// ============================================================================
// Barometer compensation unit
// Turns raw temperature and pressure readings into compensated values.
// ============================================================================
`default_nettype none

module barometer_compensation_unit #(
    parameter int RAW_BITS = baro_comp_pkg::RAW_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Input stream. s_tdata, from bit 0: temperature_raw[23:0], pressure_raw[47:24].
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [baro_comp_pkg::S_TDATA_W-1:0]  s_tdata,
    // Result stream. m_tdata, from bit 0: temperature_out[23:0], pressure_out[55:24].
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [baro_comp_pkg::M_TDATA_W-1:0]       m_tdata,
    // Configuration write port.
    input  wire logic                                 cfg_we,
    input  wire logic [baro_comp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [baro_comp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import baro_comp_pkg::*;

    // Configuration registers. Bits above each register's width are dropped
    // on write, and a write to an unknown index is ignored.
    logic [2:0]  tscale_reg, tscale_next;
    logic [2:0]  pscale_reg, pscale_next;
    logic [23:0] c0c1_reg, c0c1_next;
    logic [39:0] c00c10_reg, c00c10_next;
    logic [31:0] c01c11_reg, c01c11_next;
    logic [47:0] c2x_reg, c2x_next;

    coef_t     coef;
    item_msg_t push;
    item_msg_t head;
    logic      q_full;
    logic      pop;

    always_comb begin
        tscale_next = tscale_reg;
        pscale_next = pscale_reg;
        c0c1_next   = c0c1_reg;
        c00c10_next = c00c10_reg;
        c01c11_next = c01c11_reg;
        c2x_next    = c2x_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_TEMP_SCALE:  tscale_next = cfg_wdata[2:0];
                REG_PRESS_SCALE: pscale_next = cfg_wdata[2:0];
                REG_C0_C1:       c0c1_next   = cfg_wdata[23:0];
                REG_C00_C10:     c00c10_next = cfg_wdata[39:0];
                REG_C01_C11:     c01c11_next = cfg_wdata[31:0];
                REG_C20_C21_C30: c2x_next    = cfg_wdata[47:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tscale_reg <= '0;
            pscale_reg <= '0;
            c0c1_reg   <= '0;
            c00c10_reg <= '0;
            c01c11_reg <= '0;
            c2x_reg    <= '0;
        end else begin
            tscale_reg <= tscale_next;
            pscale_reg <= pscale_next;
            c0c1_reg   <= c0c1_next;
            c00c10_reg <= c00c10_next;
            c01c11_reg <= c01c11_next;
            c2x_reg    <= c2x_next;
        end
    end

    // Unpack the coefficient fields; each one is taken as two's complement.
    always_comb begin
        coef.t_idx = tscale_reg;
        coef.p_idx = pscale_reg;
        coef.c0    = $signed(c0c1_reg[23:12]);
        coef.c1    = $signed(c0c1_reg[11:0]);
        coef.c00   = $signed(c00c10_reg[39:20]);
        coef.c10   = $signed(c00c10_reg[19:0]);
        coef.c01   = $signed(c01c11_reg[31:16]);
        coef.c11   = $signed(c01c11_reg[15:0]);
        coef.c20   = $signed(c2x_reg[47:32]);
        coef.c21   = $signed(c2x_reg[31:16]);
        coef.c30   = $signed(c2x_reg[15:0]);
    end

    // The front end takes transfers and hands them to the queue, so input
    // transfers keep flowing while the datapath waits on the output side.
    baro_comp_front #(
        .RAW_BITS (RAW_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push)
    );

    baro_comp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .q_full  (q_full),
        .pop     (pop),
        .head    (head)
    );

    // The datapath advances as a whole whenever its output register is free
    // or being drained, and pops one queue entry per advancing cycle when the queue holds one.
    baro_comp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .coef     (coef),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== design/baro_comp_front.sv =====
// ============================================================================
// Barometer compensation front end
// Accepts raw reading pairs, sign-extends them and pushes them to the queue.
// ============================================================================
`default_nettype none

module baro_comp_front #(
    parameter int RAW_BITS = baro_comp_pkg::RAW_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [baro_comp_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                                q_full,
    output baro_comp_pkg::item_msg_t                 push
);
    import baro_comp_pkg::*;

    localparam int SH = RAW_W - RAW_BITS;

    logic      vld_reg, vld_next;
    raw_item_t item_reg, item_next;
    logic [RAW_W-1:0] t_sh, p_sh;
    logic      take;

    always_comb begin
        take      = s_tvalid && s_tready;
        // Only the low RAW_BITS bits count; they are sign extended.
        t_sh      = s_tdata[RAW_W-1:0] << SH;
        p_sh      = s_tdata[2*RAW_W-1:RAW_W] << SH;
        item_next = item_reg;
        if (take) begin
            item_next.traw = $signed(t_sh) >>> SH;
            item_next.praw = $signed(p_sh) >>> SH;
        end
        vld_next = take || (vld_reg && q_full);
    end

    assign s_tready  = !vld_reg || !q_full;
    assign push.vld  = vld_reg && !q_full;
    assign push.item = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

// ===== design/baro_comp_queue.sv =====
// ============================================================================
// Barometer compensation item queue
// Short first-in first-out buffer between the front end and the datapath.
// ============================================================================
`default_nettype none

module baro_comp_queue (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire baro_comp_pkg::item_msg_t  push,
    output logic                           q_full,
    input  wire logic                      pop,
    output baro_comp_pkg::item_msg_t       head
);
    import baro_comp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    raw_item_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    always_comb begin
        do_push     = push.vld && !q_full;
        do_pop      = pop && (cnt_reg != '0);
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    assign q_full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head.vld  = (cnt_reg != '0);
    assign head.item = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_push_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("queue count did not grow on push");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

// ===== design/baro_comp_back.sv =====
// ============================================================================
// Barometer compensation datapath
// Scales the raw readings and evaluates the calibration polynomials.
// ============================================================================
`default_nettype none

module baro_comp_back (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire baro_comp_pkg::item_msg_t            head,
    output logic                                     pop,
    input  wire baro_comp_pkg::coef_t                coef,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [baro_comp_pkg::M_TDATA_W-1:0]      m_tdata
);
    import baro_comp_pkg::*;

    localparam int NSTG = 10;

    logic            en;
    logic [NSTG-1:0] vld_reg, vld_next;

    // Scaling lanes: lane 0 is temperature, lane 1 is pressure.
    logic signed [23:0] raw1 [2];
    logic [2:0]  idx1 [2];
    logic [23:0] mag1 [2];
    logic [40:0] num1 [2];
    logic [27:0] x1_reg [2], x1_next [2];
    logic        neg1_reg [2], neg1_next [2];
    logic [2:0]  idx1_reg [2];
    logic [59:0] prod2 [2];
    logic [27:0] q0_reg [2], q0_next [2];
    logic [27:0] x2_reg [2];
    logic        neg2_reg [2];
    logic [2:0]  idx2_reg [2];
    logic [35:0] r3 [2];
    logic [27:0] q3v [2];
    logic signed [22:0] sv3 [2];
    logic signed [22:0] s3_reg [2], s3_next [2];

    // Polynomial stages.
    logic signed [34:0] c1tr_reg, c1tr_next;
    logic signed [38:0] c30pr_reg, c30pr_next, c21pr_reg, c21pr_next;
    logic signed [45:0] trpr_reg, trpr_next;
    logic signed [38:0] c01tr4_reg, c01tr4_next;
    logic signed [22:0] pr4_reg;
    logic signed [35:0] t16;
    logic signed [35:0] tfull;
    logic signed [23:0] tout5_reg, tout5_next;
    logic signed [39:0] a5_reg, a5_next, c5_reg, c5_next;
    logic signed [31:0] tp5_reg, tp5_next;
    logic signed [38:0] c01tr5_reg;
    logic signed [22:0] pr5_reg;
    logic signed [43:0] aplo_reg, aplo_next, aphi_reg, aphi_next;
    logic signed [52:0] tclo_reg, tclo_next, tchi_reg, tchi_next;
    logic signed [22:0] pr6_reg;
    logic signed [38:0] c01tr6_reg;
    logic signed [23:0] tout6_reg;
    logic signed [63:0] aprod, tcprod;
    logic signed [47:0] ra;
    logic signed [47:0] b7_reg, b7_next, q3_7_reg, q3_7_next;
    logic signed [22:0] pr7_reg;
    logic signed [38:0] c01tr7_reg;
    logic signed [23:0] tout7_reg;
    logic signed [47:0] bplo_reg, bplo_next, bphi_reg, bphi_next;
    logic signed [47:0] q3_8_reg;
    logic signed [38:0] c01tr8_reg;
    logic signed [23:0] tout8_reg;
    logic signed [63:0] bprod;
    logic signed [47:0] q2_9_reg, q2_9_next, q3_9_reg;
    logic signed [38:0] c01tr9_reg;
    logic signed [23:0] tout9_reg;
    logic signed [55:0] p16, pfull;
    logic signed [31:0] pout_reg, pout_next;
    logic signed [23:0] tout_reg;

    localparam logic signed [35:0] TMAX = 36'sd8388607;
    localparam logic signed [35:0] TMIN = -36'sd8388608;
    localparam logic signed [55:0] PMAX = 56'sd2147483647;
    localparam logic signed [55:0] PMIN = -56'sd2147483648;

    assign en       = !vld_reg[NSTG-1] || m_tready;
    assign pop      = en && head.vld;
    assign vld_next = {vld_reg[NSTG-2:0], head.vld};
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {pout_reg, tout_reg};

    // Divide by the scale factor: strip the power of two, then divide by
    // the odd part through a reciprocal multiply and one correction step.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            raw1[l] = (l == 0) ? head.item.traw : head.item.praw;
            idx1[l] = (l == 0) ? coef.t_idx : coef.p_idx;
            neg1_next[l] = raw1[l][23];
            mag1[l] = raw1[l][23] ? ($unsigned(~raw1[l]) + 24'd1) : $unsigned(raw1[l]);
            num1[l] = {1'b0, mag1[l], 16'd0} + {19'd0, scale_half(idx1[l])};
            x1_next[l] = scale_wide(idx1[l]) ? {6'd0, num1[l][40:19]} : num1[l][40:13];
            prod2[l] = 60'(x1_reg[l]) * 60'(scale_recip(idx1_reg[l]));
            q0_next[l] = prod2[l][59:32];
            r3[l] = 36'(x2_reg[l]) - 36'(q0_reg[l]) * 36'(scale_div(idx2_reg[l]));
            q3v[l] = (r3[l] >= 36'(scale_div(idx2_reg[l]))) ? q0_reg[l] + 28'd1
                                                            : q0_reg[l];
            sv3[l] = $signed({1'b0, q3v[l][21:0]});
            s3_next[l] = neg2_reg[l] ? -sv3[l] : sv3[l];
        end
    end

    always_comb begin
        c1tr_next   = 35'(coef.c1) * 35'(s3_reg[0]);
        c30pr_next  = 39'(coef.c30) * 39'(s3_reg[1]);
        c21pr_next  = 39'(coef.c21) * 39'(s3_reg[1]);
        trpr_next   = 46'(s3_reg[0]) * 46'(s3_reg[1]);
        c01tr4_next = 39'(coef.c01) * 39'(s3_reg[0]);

        t16   = (36'(coef.c0) <<< 15) + 36'(c1tr_reg);
        tfull = (t16 + 36'sd128) >>> 8;
        if (tfull > TMAX) begin
            tout5_next = 24'(TMAX);
        end else if (tfull < TMIN) begin
            tout5_next = 24'(TMIN);
        end else begin
            tout5_next = 24'(tfull);
        end
        a5_next  = (40'(coef.c20) <<< 16) + 40'(c30pr_reg);
        tp5_next = 32'((trpr_reg + 46'sd32768) >>> 16);
        c5_next  = (40'(coef.c11) <<< 16) + 40'(c21pr_reg);

        aplo_next = 44'($signed({1'b0, a5_reg[19:0]})) * 44'(pr5_reg);
        aphi_next = 44'($signed(a5_reg[39:20])) * 44'(pr5_reg);
        tclo_next = 53'($signed({1'b0, c5_reg[19:0]})) * 53'(tp5_reg);
        tchi_next = 53'($signed(c5_reg[39:20])) * 53'(tp5_reg);

        aprod     = (64'(aphi_reg) <<< 20) + 64'(aplo_reg);
        ra        = 48'((aprod + 64'sd32768) >>> 16);
        b7_next   = (48'(coef.c10) <<< 16) + ra;
        tcprod    = (64'(tchi_reg) <<< 20) + 64'(tclo_reg);
        q3_7_next = 48'((tcprod + 64'sd32768) >>> 16);

        bplo_next = 48'($signed({1'b0, b7_reg[23:0]})) * 48'(pr7_reg);
        bphi_next = 48'($signed(b7_reg[47:24])) * 48'(pr7_reg);

        bprod     = (64'(bphi_reg) <<< 24) + 64'(bplo_reg);
        q2_9_next = 48'((bprod + 64'sd32768) >>> 16);

        p16   = (56'(coef.c00) <<< 16) + 56'(q2_9_reg) + 56'(q3_9_reg) + 56'(c01tr9_reg);
        pfull = (p16 + 56'sd512) >>> 10;
        if (pfull > PMAX) begin
            pout_next = 32'(PMAX);
        end else if (pfull < PMIN) begin
            pout_next = 32'(PMIN);
        end else begin
            pout_next = 32'(pfull);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                x1_reg[l]   <= x1_next[l];
                neg1_reg[l] <= neg1_next[l];
                idx1_reg[l] <= idx1[l];
                q0_reg[l]   <= q0_next[l];
                x2_reg[l]   <= x1_reg[l];
                neg2_reg[l] <= neg1_reg[l];
                idx2_reg[l] <= idx1_reg[l];
                s3_reg[l]   <= s3_next[l];
            end
            c1tr_reg   <= c1tr_next;
            c30pr_reg  <= c30pr_next;
            c21pr_reg  <= c21pr_next;
            trpr_reg   <= trpr_next;
            c01tr4_reg <= c01tr4_next;
            pr4_reg    <= s3_reg[1];
            tout5_reg  <= tout5_next;
            a5_reg     <= a5_next;
            tp5_reg    <= tp5_next;
            c5_reg     <= c5_next;
            c01tr5_reg <= c01tr4_reg;
            pr5_reg    <= pr4_reg;
            aplo_reg   <= aplo_next;
            aphi_reg   <= aphi_next;
            tclo_reg   <= tclo_next;
            tchi_reg   <= tchi_next;
            pr6_reg    <= pr5_reg;
            c01tr6_reg <= c01tr5_reg;
            tout6_reg  <= tout5_reg;
            b7_reg     <= b7_next;
            q3_7_reg   <= q3_7_next;
            pr7_reg    <= pr6_reg;
            c01tr7_reg <= c01tr6_reg;
            tout7_reg  <= tout6_reg;
            bplo_reg   <= bplo_next;
            bphi_reg   <= bphi_next;
            q3_8_reg   <= q3_7_reg;
            c01tr8_reg <= c01tr7_reg;
            tout8_reg  <= tout7_reg;
            q2_9_reg   <= q2_9_next;
            q3_9_reg   <= q3_8_reg;
            c01tr9_reg <= c01tr8_reg;
            tout9_reg  <= tout8_reg;
            pout_reg   <= pout_next;
            tout_reg   <= tout9_reg;
        end
    end

endmodule

`default_nettype wire

// ===== tb/barometer_compensation_unit_tb.sv =====
// ============================================================================
// Barometer compensation unit testbench
// Streams raw temperature and pressure readings through the block under
// several oversampling and coefficient settings, and checks every result
// against a fixed-point predictor of the compensation polynomials.
// ============================================================================
`default_nettype none

// Keeps the expected compensated readings in arrival order and checks each
// result transfer against the oldest one.
class baro_scoreboard;
    logic [2:0]  t_idx, p_idx;
    logic [23:0] c0_c1;
    logic [39:0] c00_c10;
    logic [31:0] c01_c11;
    logic [47:0] c20_c21_c30;
    logic [55:0] pending_readings[$];
    int          mismatches;

    function new();
        t_idx = '0; p_idx = '0; c0_c1 = '0; c00_c10 = '0;
        c01_c11 = '0; c20_c21_c30 = '0; mismatches = 0;
    endfunction

    // Mirrors a register write; indexes outside the map change nothing.
    function void write_reg(logic [2:0] idx, logic [47:0] val);
        case (idx)
            baro_comp_pkg::REG_TEMP_SCALE:  t_idx = val[2:0];
            baro_comp_pkg::REG_PRESS_SCALE: p_idx = val[2:0];
            baro_comp_pkg::REG_C0_C1:       c0_c1 = val[23:0];
            baro_comp_pkg::REG_C00_C10:     c00_c10 = val[39:0];
            baro_comp_pkg::REG_C01_C11:     c01_c11 = val[31:0];
            baro_comp_pkg::REG_C20_C21_C30: c20_c21_c30 = val[47:0];
            default: ;
        endcase
    endfunction

    static function longint scale_of(logic [2:0] idx);
        longint k;
        case (idx)
            3'd0: k = 524288;
            3'd1: k = 1572864;
            3'd2: k = 3670016;
            3'd3: k = 7864320;
            3'd4: k = 253952;
            3'd5: k = 516096;
            3'd6: k = 1040384;
            default: k = 2088960;
        endcase
        return k;
    endfunction

    // raw * 2^16 / k, rounded half away from zero.
    static function longint to_q16(longint raw, longint k);
        longint n, m, q;
        n = raw * 65536;
        m = (n < 0) ? -n : n;
        q = (m + k / 2) / k;
        return (n < 0) ? -q : q;
    endfunction

    // Arithmetic shift is a floor, so this rounds ties upward.
    static function longint rnd(longint x, int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function void note_input(logic [47:0] raw);
        longint c0, c1, c00, c10, c01, c11, c20, c21, c30;
        longint tr, pr, t16, tout, a, b, q2, tp, c, q3, p16, pout;
        c0  = longint'($signed(c0_c1[23:12]));
        c1  = longint'($signed(c0_c1[11:0]));
        c00 = longint'($signed(c00_c10[39:20]));
        c10 = longint'($signed(c00_c10[19:0]));
        c01 = longint'($signed(c01_c11[31:16]));
        c11 = longint'($signed(c01_c11[15:0]));
        c20 = longint'($signed(c20_c21_c30[47:32]));
        c21 = longint'($signed(c20_c21_c30[31:16]));
        c30 = longint'($signed(c20_c21_c30[15:0]));
        tr = to_q16(longint'($signed(raw[23:0])), scale_of(t_idx));
        pr = to_q16(longint'($signed(raw[47:24])), scale_of(p_idx));

        t16  = c0 * 32768 + c1 * tr;
        tout = rnd(t16, 8);
        if (tout > 64'sd8388607) tout = 64'sd8388607;
        if (tout < -64'sd8388608) tout = -64'sd8388608;

        a    = c20 * 65536 + c30 * pr;
        b    = c10 * 65536 + rnd(a * pr, 16);
        q2   = rnd(b * pr, 16);
        tp   = rnd(tr * pr, 16);
        c    = c11 * 65536 + c21 * pr;
        q3   = rnd(tp * c, 16);
        p16  = c00 * 65536 + q2 + c01 * tr + q3;
        pout = rnd(p16, 10);
        if (pout > 64'sd2147483647) pout = 64'sd2147483647;
        if (pout < -64'sd2147483648) pout = -64'sd2147483648;

        pending_readings.push_back({pout[31:0], tout[23:0]});
    endfunction

    function void check(logic [55:0] got);
        logic [55:0] want;
        if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result transfer: %h", got);
            return;
        end
        want = pending_readings.pop_front();
        if (got[23:0] !== want[23:0] || got[55:24] !== want[55:24]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch: temperature exp %0d got %0d, pressure exp %0d got %0d",
                         $signed(want[23:0]), $signed(got[23:0]),
                         $signed(want[55:24]), $signed(got[55:24]));
        end
    endfunction
endclass

module barometer_compensation_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import baro_comp_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Idle percentages of the two sides; the main sequence changes them per phase.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // Cycles left of a long output hold-off, used to back the block up.
    int rx_hold_cycles = 0;

    baro_scoreboard sb = new();

    barometer_compensation_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Result side: check each accepted transfer, then choose the next ready.
    // During a hold-off ready stays low for the whole count, which fills the
    // pipeline and queue until the block lowers s_tready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check(m_tdata);
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles <= rx_hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Writes one register; only called while nothing is in flight, and the
    // predictor is updated at the same time. The enable is low again before
    // the next write starts.
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // Offers one reading pair and waits for its transfer. Valid is not lowered
    // after the transfer, so back-to-back items keep it high.
    task automatic send_reading(logic [23:0] traw, logic [23:0] praw);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {praw, traw};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input({praw, traw});
    endtask

    // Lowers valid and waits until every expected result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_readings.size() != 0) @(posedge aclk);
    endtask

    task automatic load_setting(logic [2:0] ti, logic [2:0] pi, logic [23:0] r2,
                                logic [39:0] r3, logic [31:0] r4, logic [47:0] r5);
        write_reg(REG_TEMP_SCALE, {45'd0, ti});
        write_reg(REG_PRESS_SCALE, {45'd0, pi});
        write_reg(REG_C0_C1, {24'd0, r2});
        write_reg(REG_C00_C10, {8'd0, r3});
        write_reg(REG_C01_C11, {16'd0, r4});
        write_reg(REG_C20_C21_C30, r5);
    endtask

    // Raw values: mostly uniform, some at the extremes, some small.
    function automatic logic [23:0] pick_raw();
        case ($urandom_range(7))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 512)) - 256);
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        #50_000_000;
        $display("** barometer_compensation_unit: FAILED **");
        $finish;
    end

    initial begin
        logic [23:0] edge_raw[6];
        edge_raw = '{24'h000000, 24'h000001, 24'hffffff, 24'h7fffff, 24'h800000, 24'h004000};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With reset coefficients every result is zero.
        send_reading(24'h7fffff, 24'h800000);
        drain();

        // Largest positive coefficients, largest scaled readings: this drives
        // both outputs into saturation. Also poke the unused indexes, which
        // the block must ignore.
        load_setting(3'd4, 3'd4, 24'h7ff7ff, 40'h7ffff7ffff, 32'h7fff7fff,
                     48'h7fff7fff7fff);
        write_reg(3'd6, 48'hffffffffffff);
        write_reg(3'd7, 48'hffffffffffff);
        for (int i = 0; i < 6; i++)
            send_reading(edge_raw[i], edge_raw[5 - i]);
        drain();

        // Most negative coefficients with the largest scale factor and the largest odd divisor.
        load_setting(3'd3, 3'd7, 24'h800800, 40'h8000080000, 32'h80008000,
                     48'h800080008000);
        for (int i = 0; i < 6; i++)
            send_reading(edge_raw[i], edge_raw[i]);
        // Readings whose temperature lands exactly on a rounding tie of the scaling divide.
        send_reading(24'd60, 24'd60);
        send_reading(-24'sd60, -24'sd60);
        drain();

        // Random phases: sender-light/receiver-heavy idling, then the reverse,
        // then none at all with one long output hold-off.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 3) begin
                tx_idle_pct = 14; rx_idle_pct = 86;
            end else if (ph < 6) begin
                tx_idle_pct = 86; rx_idle_pct = 14;
            end else begin
                tx_idle_pct = 0; rx_idle_pct = 0;
            end
            load_setting(3'($urandom), 3'($urandom), 24'($urandom),
                         {8'($urandom), 32'($urandom)}, 32'($urandom),
                         {16'($urandom), 32'($urandom)});
            if (ph == 6)
                rx_hold_cycles = 200;
            for (int i = 0; i < 205; i++)
                send_reading(pick_raw(), pick_raw());
            drain();
        end

        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_readings.size() == 0) begin
            $display("** barometer_compensation_unit: PASSED **");
        end else begin
            $display("** barometer_compensation_unit: FAILED **");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== files.f =====
design/baro_comp_pkg.sv
design/baro_comp_front.sv
design/baro_comp_queue.sv
design/baro_comp_back.sv
design/barometer_compensation_unit.sv
tb/barometer_compensation_unit_tb.sv
